### src/cicw_pkg.sv
// Shared types, constants and helper functions for the word counter.
package cicw_pkg;

	localparam int MaxWord   = 64;
	localparam int Entries   = 256;
	localparam int LenW      = 6;
	localparam int EntW      = 8;
	localparam int TotW      = 9;
	localparam int LetAddrW  = EntW + LenW;
	localparam int LetDepth  = Entries * MaxWord;
	localparam int BktW      = 3;

	localparam logic [1:0] OpChar = 2'd0;
	localparam logic [1:0] OpEnd  = 2'd1;
	localparam logic [1:0] OpRead = 2'd2;

	localparam logic KindWord = 1'b0;
	localparam logic KindRead = 1'b1;

	typedef struct packed {
		logic [LenW-1:0] len;
		logic [31:0]     count;
		logic [BktW-1:0] bucket;
	} meta_t;

	// Result fields, first field in the highest bits
	typedef struct packed {
		logic            entry_valid;
		logic [LenW-1:0] word_length;
		logic [7:0]      stored_char;
		logic [BktW-1:0] bucket;
		logic            table_full;
		logic            newly_added;
		logic [31:0]     word_count;
		logic [EntW-1:0] slot;
	} res_t;

	typedef struct packed {
		logic                meta_re;
		logic [EntW-1:0]     meta_ra;
		logic                meta_we;
		logic [EntW-1:0]     meta_wa;
		meta_t               meta_wd;
		logic                let_re;
		logic [LetAddrW-1:0] let_ra;
		logic                let_we;
		logic [LetAddrW-1:0] let_wa;
		logic [7:0]          let_wd;
	} store_req_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

endpackage

### src/cicw_bucket.sv
// Bucket of a hash: nibble fold (16 = 1 mod 5) then a small reciprocal reduction.
module cicw_bucket (
	input  logic                      clk,
	input  logic [31:0]               hash,
	output logic [cicw_pkg::BktW-1:0] bucket
);
	import cicw_pkg::*;

	logic [6:0]  sum_s1;
	logic [6:0]  fold;
	logic [13:0] prod;
	logic [5:0]  quot;
	logic [6:0]  rem;
	logic [6:0]  rem_c;

	always_comb begin
		fold = 7'd0;
		for (int k = 0; k < 8; k++) begin
			fold = fold + {3'd0, hash[4*k +: 4]};
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= fold;
	end

	// quotient by 51/256 runs at most one low
	always_comb begin
		prod  = {7'd0, sum_s1} * 14'd51;
		quot  = prod[13:8];
		rem   = sum_s1 - {1'b0, quot} * 7'd5;
		rem_c = (rem >= 7'd5) ? rem - 7'd5 : rem;
	end

	always_ff @(posedge clk) begin
		bucket <= rem_c[BktW-1:0];
	end

endmodule

### src/cicw_store.sv
// Entry store: letter memory and per-entry length/count/bucket memory.
module cicw_store (
	input  logic                 clk,
	input  cicw_pkg::store_req_t req,
	output cicw_pkg::meta_t      meta_rd,
	output logic [7:0]           let_rd
);
	import cicw_pkg::*;

	logic [7:0] let_mem [LetDepth];
	meta_t      meta_mem [Entries];

	always_ff @(posedge clk) begin
		if (req.let_we) begin
			let_mem[req.let_wa] <= req.let_wd;
		end
		if (req.let_re) begin
			let_rd <= let_mem[req.let_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (req.meta_we) begin
			meta_mem[req.meta_wa] <= req.meta_wd;
		end
		if (req.meta_re) begin
			meta_rd <= meta_mem[req.meta_ra];
		end
	end

endmodule

### src/case_insensitive_word_counter_core.sv
// Top level: input decode, pending word buffer, lookup sequencer and result register.
//
// Stream in (s_*): tuser carries the opcode, tdata the character, entry index
// and letter position. Stream out (m_*): tuser is the result kind, tdata the
// result fields. Letters are taken one per cycle while the sequencer waits
// for input, and give no result. A word end (non-letter, end op or the 63rd
// letter) starts a lookup: bucket reduction in S_FOLD and S_BKT, then S_SCAN
// and S_META per stored entry visited, plus S_CRD and S_CCK per letter
// compared in an entry whose bucket and length match; a new word is then
// copied letter by letter through S_CPRD and S_CPWR. Lookup time is set by
// the single-read entry store. A read op's result is registered in S_RD.
// s_tready is high only while the sequencer waits for input; a letter may be
// taken while an earlier result still waits in the output register. A stalled
// receiver holds the result and the sequencer waits before loading the next.
// Reset empties the table and the pending word; no clearing pass is needed,
// as entries are only read below the entry total.
module case_insensitive_word_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_byte[7:0], entry_index[15:8], char_position[21:16]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // slot, word_count, newly_added, table_full, bucket,
	                               // stored_char, word_length, entry_valid
	output logic [0:0]  m_tuser    // result_kind
);
	import cicw_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD   = 11'b00000000010,
		S_FOLD = 11'b00000000100,
		S_BKT  = 11'b00000001000,
		S_SCAN = 11'b00000010000,
		S_META = 11'b00000100000,
		S_CRD  = 11'b00001000000,
		S_CCK  = 11'b00010000000,
		S_CPRD = 11'b00100000000,
		S_CPWR = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t          state_q;
	logic [LenW-1:0] plen_q;
	logic [31:0]     hash_q;
	logic [TotW-1:0] total_q;
	logic [TotW-1:0] e_q;
	logic [LenW-1:0] i_q;
	logic [31:0]     cnt_q;
	logic [EntW-1:0] ridx_q;
	logic [LenW-1:0] rpos_q;
	logic            kind_q;
	res_t            res_q;
	logic            m_valid_q;
	res_t            m_res_q;
	logic            m_kind_q;

	logic [7:0]      pend_mem [MaxWord];
	logic [7:0]      pend_rd_q;

	store_req_t      req;
	meta_t           meta_rd;
	logic [7:0]      let_rd;
	logic [BktW-1:0] bucket;

	logic [1:0]      in_op;
	logic [7:0]      in_char;
	logic [EntW-1:0] in_idx;
	logic [LenW-1:0] in_pos;
	logic            accept;
	logic            out_free;
	logic            last_i;

	res_t            res_rd;
	res_t            res_nw;
	res_t            res_hit;

	assign in_op    = s_tuser;
	assign in_char  = s_tdata[7:0];
	assign in_idx   = s_tdata[15:8];
	assign in_pos   = s_tdata[21:16];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign last_i   = (i_q == plen_q - LenW'(1));

	cicw_bucket u_bucket (
		.clk    (clk),
		.hash   (hash_q),
		.bucket (bucket)
	);

	cicw_store u_store (
		.clk     (clk),
		.req     (req),
		.meta_rd (meta_rd),
		.let_rd  (let_rd)
	);

	always_comb begin
		req         = '0;
		req.meta_wd = '0;
		unique case (state_q)
			S_IDLE: begin
				req.meta_re = accept && (in_op == OpRead);
				req.meta_ra = in_idx;
				req.let_re  = accept && (in_op == OpRead);
				req.let_ra  = {in_idx, in_pos};
			end
			S_SCAN: begin
				req.meta_re = 1'b1;
				req.meta_ra = e_q[EntW-1:0];
			end
			S_CRD: begin
				req.let_re = 1'b1;
				req.let_ra = {e_q[EntW-1:0], i_q};
			end
			S_CCK: begin
				req.meta_we = (to_lower(let_rd) == to_lower(pend_rd_q)) && last_i;
				req.meta_wa = e_q[EntW-1:0];
				req.meta_wd = '{len: plen_q,
				                count: (&cnt_q) ? cnt_q : cnt_q + 32'd1,
				                bucket: bucket};
			end
			S_CPWR: begin
				req.let_we  = 1'b1;
				req.let_wa  = {total_q[EntW-1:0], i_q};
				req.let_wd  = pend_rd_q;
				req.meta_we = last_i;
				req.meta_wa = total_q[EntW-1:0];
				req.meta_wd = '{len: plen_q, count: 32'd1, bucket: bucket};
			end
			default: ;
		endcase
	end

	// result words for a read, a new or dropped word, and a found word
	always_comb begin
		res_rd      = '0;
		res_rd.slot = ridx_q;
		if ({1'b0, ridx_q} < total_q) begin
			res_rd.entry_valid = 1'b1;
			res_rd.word_count  = meta_rd.count;
			res_rd.bucket      = meta_rd.bucket;
			res_rd.word_length = meta_rd.len;
			res_rd.stored_char = (rpos_q < meta_rd.len) ? let_rd : 8'd0;
		end

		res_nw             = '0;
		res_nw.bucket      = bucket;
		res_nw.word_length = plen_q;
		if (total_q == TotW'(Entries)) begin
			res_nw.table_full = 1'b1;
		end else begin
			res_nw.entry_valid = 1'b1;
			res_nw.newly_added = 1'b1;
			res_nw.word_count  = 32'd1;
			res_nw.slot        = total_q[EntW-1:0];
		end

		res_hit             = '0;
		res_hit.bucket      = bucket;
		res_hit.word_length = plen_q;
		res_hit.entry_valid = 1'b1;
		res_hit.slot        = e_q[EntW-1:0];
		res_hit.word_count  = (&cnt_q) ? cnt_q : cnt_q + 32'd1;
	end

	// pending word buffer
	always_ff @(posedge clk) begin
		if (accept && in_op == OpChar && is_letter(in_char) && plen_q < LenW'(MaxWord - 1)) begin
			pend_mem[plen_q] <= in_char;
		end
		if (state_q == S_CRD || state_q == S_CPRD) begin
			pend_rd_q <= pend_mem[i_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			plen_q    <= '0;
			hash_q    <= '0;
			total_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (in_op == OpChar && is_letter(in_char)) begin
							if (plen_q < LenW'(MaxWord - 1)) begin
								plen_q <= plen_q + LenW'(1);
								hash_q <= (hash_q << 5) - hash_q + {24'd0, to_lower(in_char)};
							end
							if (plen_q >= LenW'(MaxWord - 2)) begin
								state_q <= S_FOLD;
							end
						end else if ((in_op == OpChar || in_op == OpEnd) && plen_q != '0) begin
							state_q <= S_FOLD;
						end else if (in_op == OpRead) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD:   state_q <= S_DONE;
				S_FOLD: state_q <= S_BKT;
				S_BKT:  state_q <= S_SCAN;
				S_SCAN: begin
					if (e_q == total_q) begin
						state_q <= (total_q == TotW'(Entries)) ? S_DONE : S_CPRD;
					end else begin
						state_q <= S_META;
					end
				end
				S_META: begin
					state_q <= (meta_rd.bucket == bucket && meta_rd.len == plen_q) ? S_CRD : S_SCAN;
				end
				S_CRD:  state_q <= S_CCK;
				S_CCK: begin
					if (to_lower(let_rd) != to_lower(pend_rd_q)) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= last_i ? S_DONE : S_CRD;
					end
				end
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					if (last_i) begin
						total_q <= total_q + TotW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_CPRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (kind_q == KindWord) begin
							plen_q <= '0;
							hash_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				e_q    <= '0;
				ridx_q <= in_idx;
				rpos_q <= in_pos;
				kind_q <= (in_op == OpRead) ? KindRead : KindWord;
			end
			S_RD: begin
				res_q <= res_rd;
			end
			S_SCAN: begin
				i_q <= '0;
				if (e_q == total_q) begin
					res_q <= res_nw;
				end
			end
			S_META: begin
				cnt_q <= meta_rd.count;
				i_q   <= '0;
				if (!(meta_rd.bucket == bucket && meta_rd.len == plen_q)) begin
					e_q <= e_q + TotW'(1);
				end
			end
			S_CCK: begin
				if (to_lower(let_rd) != to_lower(pend_rd_q)) begin
					e_q <= e_q + TotW'(1);
				end else if (last_i) begin
					res_q <= res_hit;
				end else begin
					i_q <= i_q + LenW'(1);
				end
			end
			S_CPWR: begin
				i_q <= i_q + LenW'(1);
			end
			S_DONE: begin
				if (out_free) begin
					m_res_q  <= res_q;
					m_kind_q <= kind_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, m_res_q};
	assign m_tuser  = m_kind_q;

`ifndef SYNTHESIS
	a_plen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= LenW'(MaxWord - 1))
		else $error("pending length beyond word limit");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TotW'(Entries))
		else $error("entry total beyond table size");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CPWR && last_i) |=> total_q == $past(total_q) + TotW'(1))
		else $error("new entry not counted");

	a_word_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && kind_q == KindWord) |=> plen_q == '0 && hash_q == '0)
		else $error("pending word not cleared after result");
`endif

endmodule

### dv/case_insensitive_word_counter_core_tb.sv
// Self-checking testbench for the word counter core: predicts each result and compares.
module case_insensitive_word_counter_core_tb;
	import cicw_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // char_byte, entry_index, char_position
	logic [1:0]  s_tuser = '0;   // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // slot, word_count, newly_added, table_full, bucket,
	                             // stored_char, word_length, entry_valid
	logic [0:0]  m_tuser;        // result_kind

	case_insensitive_word_counter_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic  kind;
		res_t  res;
	} word_res_t;

	// predictor state
	logic [7:0]  pend_word [MaxWord];
	int          pend_len;
	logic [31:0] pend_hash;
	int          tbl_total;
	logic [7:0]  tbl_letters [Entries][MaxWord];
	int          tbl_len [Entries];
	logic [31:0] tbl_count [Entries];
	logic [2:0]  tbl_bucket [Entries];

	word_res_t awaited_q [$];
	int        errors;
	int        words_seen, reads_seen, fulls_seen;
	int        send_idle_pct, recv_stall_pct;
	bit        long_hold;

	function automatic logic letter_p(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] lower_p(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void close_word();
		word_res_t r;
		logic [2:0] b;
		int hit;
		bit same;
		b = 3'(pend_hash % 5);
		r.kind = KindWord;
		r.res = '0;
		r.res.bucket = b;
		r.res.word_length = pend_len[5:0];
		hit = -1;
		for (int e = 0; e < tbl_total && hit < 0; e++) begin
			if (tbl_bucket[e] == b && tbl_len[e] == pend_len) begin
				same = 1;
				for (int i = 0; i < pend_len; i++)
					if (lower_p(tbl_letters[e][i]) != lower_p(pend_word[i])) same = 0;
				if (same) hit = e;
			end
		end
		if (hit >= 0) begin
			if (tbl_count[hit] != 32'hffff_ffff) tbl_count[hit]++;
			r.res.slot = hit[7:0];
			r.res.word_count = tbl_count[hit];
			r.res.entry_valid = 1'b1;
		end else if (tbl_total < Entries) begin
			for (int i = 0; i < pend_len; i++) tbl_letters[tbl_total][i] = pend_word[i];
			tbl_len[tbl_total] = pend_len;
			tbl_count[tbl_total] = 32'd1;
			tbl_bucket[tbl_total] = b;
			r.res.slot = tbl_total[7:0];
			r.res.word_count = 32'd1;
			r.res.newly_added = 1'b1;
			r.res.entry_valid = 1'b1;
			tbl_total++;
		end else begin
			r.res.table_full = 1'b1;
		end
		pend_len = 0;
		pend_hash = 32'd0;
		awaited_q.push_back(r);
	endfunction

	function automatic void predict_item(logic [1:0] op, logic [7:0] c, logic [7:0] idx,
			logic [5:0] pos);
		word_res_t r;
		case (op)
			OpChar: begin
				if (!letter_p(c)) begin
					if (pend_len > 0) close_word();
				end else begin
					pend_word[pend_len] = c;
					pend_len++;
					pend_hash = {24'd0, lower_p(c)} + 32'd31 * pend_hash;
					if (pend_len >= MaxWord - 1) close_word();
				end
			end
			OpEnd: if (pend_len > 0) close_word();
			OpRead: begin
				r.kind = KindRead;
				r.res = '0;
				r.res.slot = idx;
				if (idx < tbl_total) begin
					r.res.word_count = tbl_count[idx];
					r.res.bucket = tbl_bucket[idx];
					if (pos < tbl_len[idx]) r.res.stored_char = tbl_letters[idx][pos];
					r.res.word_length = tbl_len[idx][5:0];
					r.res.entry_valid = 1'b1;
				end
				awaited_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// tvalid stays up after a transfer until the next item or an idle cycle replaces it
	task automatic send_item(logic [1:0] op, logic [7:0] c, logic [7:0] idx = 0,
			logic [5:0] pos = 0);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, pos, idx, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(op, c, idx, pos);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	// result checker
	always @(posedge clk) begin
		word_res_t w;
		res_t g;
		if (m_tvalid && m_tready) begin
			g = m_tdata[59:0];
			if (awaited_q.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata, 0);
			end else begin
				w = awaited_q.pop_front();
				if (m_tuser[0] != w.kind) report_mismatch("result_kind", m_tuser, w.kind);
				if (g.slot != w.res.slot) report_mismatch("slot", g.slot, w.res.slot);
				if (g.word_count != w.res.word_count)
					report_mismatch("word_count", g.word_count, w.res.word_count);
				if (g.newly_added != w.res.newly_added)
					report_mismatch("newly_added", g.newly_added, w.res.newly_added);
				if (g.table_full != w.res.table_full)
					report_mismatch("table_full", g.table_full, w.res.table_full);
				if (g.bucket != w.res.bucket) report_mismatch("bucket", g.bucket, w.res.bucket);
				if (g.stored_char != w.res.stored_char)
					report_mismatch("stored_char", g.stored_char, w.res.stored_char);
				if (g.word_length != w.res.word_length)
					report_mismatch("word_length", g.word_length, w.res.word_length);
				if (g.entry_valid != w.res.entry_valid)
					report_mismatch("entry_valid", g.entry_valid, w.res.entry_valid);
				if (w.kind == KindRead) reads_seen++;
				else if (w.res.table_full) fulls_seen++;
				else words_seen++;
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (long_hold) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic send_word(string s);
		for (int i = 0; i < s.len(); i++) send_item(OpChar, s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'(8'h61 + $urandom_range(25));
		if ($urandom_range(1)) c = c - 8'd32;
		return c;
	endfunction

	task automatic test_directed();
		send_item(OpEnd, 0);              // end with nothing pending
		send_item(OpChar, " ");           // separator with nothing pending
		send_item(OpRead, 0, 8'd0, 6'd0); // missing entry
		send_word("Hello "); send_word("hELLO."); send_word("z");
		send_item(OpEnd, 0);
		send_item(2'd3, 8'hff, 8'hff, 6'h3f); // ignored op
		send_item(OpRead, 0, 8'd0, 6'd4);
		send_item(OpRead, 0, 8'd0, 6'd63);    // past end
		send_item(OpRead, 0, 8'd1, 6'd0);
		send_item(OpRead, 0, 8'd255, 6'd0);
		for (int i = 0; i < 70; i++) send_item(OpChar, (i % 2) ? "Z" : "a"); // word cut
		send_item(OpChar, 8'hff);
		drain();
	endtask

	task automatic random_traffic(int n);
		int k;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0: begin
					send_item(OpRead, 0, 8'($urandom_range(255)), 6'($urandom()));
					k++;
				end
				1: begin
					send_item(2'($urandom()), 8'($urandom()), 8'($urandom()), 6'($urandom()));
					k++;
				end
				default: begin
					// small vocabulary so repeats are common
					int len;
					len = (tbl_total < 200) ? $urandom_range(1, 3) : $urandom_range(1, 4);
					if ($urandom_range(40) == 0) len = $urandom_range(50, 66);
					for (int i = 0; i < len; i++)
						send_item(OpChar,
							($urandom_range(3) == 0) ? 8'("a" + (i % 3)) : rand_letter());
					if ($urandom_range(4) == 0) send_item(OpEnd, 0);
					else send_item(OpChar, $urandom_range(1) ? 8'h20 : 8'($urandom()));
					k += len + 1;
				end
			endcase
		end
		send_item(OpEnd, 0);
		drain();
	endtask

	task automatic test_pressure();
		fork
			begin long_hold = 1; repeat (600) @(posedge clk); long_hold = 0; end
			begin
				for (int i = 0; i < 8; i++) begin
					send_item(OpRead, 0, 8'(i), i[5:0]);
					send_word("ab ");
				end
			end
		join
		drain();
	endtask

	task automatic test_fill_table();
		// distinct two-letter words until the table overflows, then a few dropped ones
		int i;
		int extra;
		send_idle_pct = 0; recv_stall_pct = 0;
		i = 0;
		extra = 0;
		while (extra < 4) begin
			if (tbl_total == Entries) extra++;
			send_item(OpChar, 8'("a" + i % 26));
			send_item(OpChar, 8'("a" + (i / 26) % 26));
			send_item(OpChar, "-");
			i++;
		end
		send_item(OpRead, 0, 8'd255, 6'd1);
		drain();
	endtask

	initial begin
		errors = 0; words_seen = 0; reads_seen = 0; fulls_seen = 0;
		pend_len = 0; pend_hash = 0; tbl_total = 0;
		send_idle_pct = 0; recv_stall_pct = 0; long_hold = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		random_traffic(40);
		send_idle_pct = 86; recv_stall_pct = 0;  random_traffic(40);
		send_idle_pct = 0;  recv_stall_pct = 86; random_traffic(40);
		send_idle_pct = 15; recv_stall_pct = 15; random_traffic(40);
		test_pressure();
		test_fill_table();
		$display("covered %0d counted words, %0d reads, %0d table-full drops",
			words_seen, reads_seen, fulls_seen);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#60000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
src/cicw_pkg.sv
src/cicw_bucket.sv
src/cicw_store.sv
src/case_insensitive_word_counter_core.sv
dv/case_insensitive_word_counter_core_tb.sv
